// File: hdl/rhs_pkg.sv
// Shared widths, limits and types for the region homogeneity statistics block.
package rhs_pkg;

  localparam int CH_W = 8;
  localparam int MAG_W = 9;
  localparam int TOL_W = 10;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(32);

  localparam int MAX_REGION_PIXELS = 1048576;
  localparam int CNT_W = $clog2(MAX_REGION_PIXELS + 1);
  localparam longint MAX_SUM = longint'(MAX_REGION_PIXELS) * ((longint'(1) << CH_W) - 1);
  localparam int SUM_W = $clog2(MAX_SUM + 1);

  // r^2+g^2+b^2 fits in 18 bits; the root is found two bits of radicand per step
  localparam int SQ_W = 18;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int SQ_STAGES = 3;
  localparam int SQ_PER_STAGE = SQ_STEPS / SQ_STAGES;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_green;
    logic [SUM_W-1:0] sum_blue;
    logic [CNT_W-1:0] pixel_count;
    logic [MAG_W-1:0] spread;
  } region_t;

  typedef struct packed {
    logic push;
  } q_wr_t;

endpackage

// File: hdl/rhs_ifs.sv
// Channel interfaces: pixel requests in, region results out, tolerance writes.
interface rhs_pixel_if;
  logic valid;
  logic ready;
  logic [rhs_pkg::CH_W-1:0] red_in;
  logic [rhs_pkg::CH_W-1:0] green_in;
  logic [rhs_pkg::CH_W-1:0] blue_in;
  logic last_pixel;
  modport source (output valid, red_in, green_in, blue_in, last_pixel, input ready);
  modport sink (input valid, red_in, green_in, blue_in, last_pixel, output ready);
endinterface

interface rhs_result_if;
  logic valid;
  logic ready;
  logic [rhs_pkg::CH_W-1:0] mean_red;
  logic [rhs_pkg::CH_W-1:0] mean_green;
  logic [rhs_pkg::CH_W-1:0] mean_blue;
  logic homogeneous;
  logic [rhs_pkg::MAG_W-1:0] magnitude_spread;
  modport source (output valid, mean_red, mean_green, mean_blue, homogeneous,
                  magnitude_spread, input ready);
  modport sink (input valid, mean_red, mean_green, mean_blue, homogeneous,
                magnitude_spread, output ready);
endinterface

interface rhs_cfg_if;
  logic valid;
  logic ready;
  logic [rhs_pkg::TOL_W-1:0] tolerance;
  modport source (output valid, tolerance, input ready);
  modport sink (input valid, tolerance, output ready);
endinterface

// File: hdl/region_homogeneity_stats.sv
// Top level: region homogeneity statistics over a stream of RGB pixels.
//
//  channel  dir  payload                                          request taken when
//  -------  ---  -----------------------------------------------  ------------------
//  pix      in   red_in, green_in, blue_in, last_pixel            pix.valid & pix.ready
//  res      out  mean_red/green/blue, homogeneous, magnitude_spread res.valid & res.ready
//  cfg      in   tolerance (10 bits, reset 32)                    cfg.valid & cfg.ready
//
// While pix.ready is high the front takes one pixel request per cycle: squares and sum
// in one stage, the 9-bit square root in three stages of three steps, then the running
// min/max, sums and count (count saturates at MAX_REGION_PIXELS).
// A marked pixel pushes its region totals into a two-entry queue. The back loads one
// region, divides the three sums by the count one quotient bit a cycle, then holds the
// result until res takes it; only then does it pop the next region.
// pix.ready falls only while a region end waits on a full queue; res stalls hold
// the back and, through the queue, eventually the front. cfg is always ready.
// Reset (rst, synchronous) empties the pipeline and queue and sets tolerance to 32.
module region_homogeneity_stats (
  input logic clk,
  input logic rst,
  rhs_pixel_if.sink pix,
  rhs_result_if.source res,
  rhs_cfg_if.sink cfg
);
  import rhs_pkg::*;

  q_wr_t q_wr_ctl;
  region_t q_wr_data;
  region_t q_rd_data;
  logic q_full;
  logic q_not_empty;
  logic q_pop;

  rhs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .q_wr_ctl  (q_wr_ctl),
    .q_full    (q_full),
    .q_wr_data (q_wr_data)
  );

  rhs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_ctl    (q_wr_ctl),
    .wr_data   (q_wr_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_data   (q_rd_data)
  );

  rhs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_rd_data),
    .q_pop       (q_pop),
    .cfg         (cfg),
    .res         (res)
  );

endmodule

// File: hdl/rhs_front.sv
// Front end: pixel magnitude pipeline and per-region accumulation.
module rhs_front (
  input  logic clk,
  input  logic rst,
  rhs_pixel_if.sink pix,
  output rhs_pkg::q_wr_t q_wr_ctl,
  input  logic q_full,
  output rhs_pkg::region_t q_wr_data
);
  import rhs_pkg::*;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic last;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    sqrt_t sq;
  } stage_t;

  // SQ_PER_STAGE digit-by-digit square root steps, starting at step 'first'
  function automatic sqrt_t sqrt_steps(sqrt_t a, int first);
    sqrt_t s;
    logic [SQ_W-1:0] bit_v;
    logic [SQ_W-1:0] trial;
    s = a;
    for (int k = 0; k < SQ_PER_STAGE; k++) begin
      bit_v = SQ_W'(1) << (SQ_W - 2 - 2 * (first + k));
      trial = s.res + bit_v;
      if (s.rem >= trial) begin
        s.rem = s.rem - trial;
        s.res = (s.res >> 1) + bit_v;
      end else begin
        s.res = s.res >> 1;
      end
    end
    return s;
  endfunction

  stage_t stg [SQ_STAGES+1];
  logic [SQ_STAGES:0] vld;

  logic [SUM_W-1:0] sum_red, sum_green, sum_blue;
  logic [CNT_W-1:0] pixel_count;
  logic [MAG_W-1:0] min_mag, max_mag;

  logic [SUM_W-1:0] sum_red_next, sum_green_next, sum_blue_next;
  logic [CNT_W-1:0] count_next;
  logic [MAG_W-1:0] min_next, max_next, mag;
  logic adv, tail_last;

  assign tail_last = vld[SQ_STAGES] && stg[SQ_STAGES].last;
  assign adv = !(tail_last && q_full);
  assign pix.ready = adv;

  always_comb begin
    mag = stg[SQ_STAGES].sq.res[MAG_W-1:0];
    min_next = (mag < min_mag) ? mag : min_mag;
    max_next = (mag > max_mag) ? mag : max_mag;
    sum_red_next = sum_red;
    sum_green_next = sum_green;
    sum_blue_next = sum_blue;
    count_next = pixel_count;
    if (pixel_count < CNT_W'(MAX_REGION_PIXELS)) begin
      sum_red_next = sum_red + SUM_W'(stg[SQ_STAGES].r);
      sum_green_next = sum_green + SUM_W'(stg[SQ_STAGES].g);
      sum_blue_next = sum_blue + SUM_W'(stg[SQ_STAGES].b);
      count_next = pixel_count + CNT_W'(1);
    end
  end

  assign q_wr_ctl.push = tail_last && !q_full;
  assign q_wr_data = '{sum_red: sum_red_next, sum_green: sum_green_next,
                       sum_blue: sum_blue_next, pixel_count: count_next,
                       spread: max_next - min_next};

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0].last <= pix.last_pixel;
      stg[0].r <= pix.red_in;
      stg[0].g <= pix.green_in;
      stg[0].b <= pix.blue_in;
      stg[0].sq.res <= '0;
      stg[0].sq.rem <= SQ_W'(pix.red_in) * SQ_W'(pix.red_in)
                     + SQ_W'(pix.green_in) * SQ_W'(pix.green_in)
                     + SQ_W'(pix.blue_in) * SQ_W'(pix.blue_in);
      for (int s = 1; s <= SQ_STAGES; s++) begin
        stg[s].last <= stg[s-1].last;
        stg[s].r <= stg[s-1].r;
        stg[s].g <= stg[s-1].g;
        stg[s].b <= stg[s-1].b;
        stg[s].sq <= sqrt_steps(stg[s-1].sq, (s - 1) * SQ_PER_STAGE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      sum_red <= '0;
      sum_green <= '0;
      sum_blue <= '0;
      pixel_count <= '0;
      min_mag <= '1;
      max_mag <= '0;
    end else if (adv) begin
      vld <= {vld[SQ_STAGES-1:0], pix.valid};
      if (vld[SQ_STAGES]) begin
        if (stg[SQ_STAGES].last) begin
          sum_red <= '0;
          sum_green <= '0;
          sum_blue <= '0;
          pixel_count <= '0;
          min_mag <= '1;
          max_mag <= '0;
        end else begin
          sum_red <= sum_red_next;
          sum_green <= sum_green_next;
          sum_blue <= sum_blue_next;
          pixel_count <= count_next;
          min_mag <= min_next;
          max_mag <= max_next;
        end
      end
    end
  end

endmodule

// File: hdl/rhs_queue.sv
// Short queue of finished region totals between front and back.
module rhs_queue (
  input  logic clk,
  input  logic rst,
  input  rhs_pkg::q_wr_t wr_ctl,
  input  rhs_pkg::region_t wr_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output rhs_pkg::region_t rd_data
);
  import rhs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  region_t entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FILL_W-1:0] fill;
  logic do_push, do_pop;

  assign full = (fill == FILL_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign do_push = wr_ctl.push && !full;
  assign do_pop = pop && not_empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      fill <= fill + FILL_W'(do_push) - FILL_W'(do_pop);
    end
  end

endmodule

// File: hdl/rhs_back.sv
// Back end: bit-serial mean division, tolerance compare and result register.
module rhs_back (
  input  logic clk,
  input  logic rst,
  input  logic q_not_empty,
  input  rhs_pkg::region_t q_data,
  output logic q_pop,
  rhs_cfg_if.sink cfg,
  rhs_result_if.source res
);
  import rhs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;
  localparam int STEP_W = $clog2(CH_W);

  logic [1:0] state;
  logic [STEP_W-1:0] step;
  logic [TOL_W-1:0] tolerance;
  logic [SUM_W-1:0] rem_r, rem_g, rem_b, divisor;
  logic [CH_W-1:0] quo_r, quo_g, quo_b;
  logic [MAG_W-1:0] spread;
  logic homog;

  assign cfg.ready = 1'b1;
  assign q_pop = (state == ST_IDLE) && q_not_empty;

  assign res.valid = (state == ST_HOLD);
  assign res.mean_red = quo_r;
  assign res.mean_green = quo_g;
  assign res.mean_blue = quo_b;
  assign res.homogeneous = homog;
  assign res.magnitude_spread = spread;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg.valid) begin
      tolerance <= cfg.tolerance;
    end
  end

  // restoring division: the mean never exceeds CH_W bits
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rem_r <= q_data.sum_red;
        rem_g <= q_data.sum_green;
        rem_b <= q_data.sum_blue;
        divisor <= SUM_W'(q_data.pixel_count) << (CH_W - 1);
        spread <= q_data.spread;
        homog <= (TOL_W'(q_data.spread) < tolerance);
      end
      ST_DIV: begin
        if (rem_r >= divisor) begin
          rem_r <= rem_r - divisor;
        end
        if (rem_g >= divisor) begin
          rem_g <= rem_g - divisor;
        end
        if (rem_b >= divisor) begin
          rem_b <= rem_b - divisor;
        end
        quo_r <= {quo_r[CH_W-2:0], rem_r >= divisor};
        quo_g <= {quo_g[CH_W-2:0], rem_g >= divisor};
        quo_b <= {quo_b[CH_W-2:0], rem_b >= divisor};
        divisor <= divisor >> 1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_not_empty) begin
            state <= ST_DIV;
            step <= '0;
          end
        end
        ST_DIV: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(CH_W - 1)) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (res.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/sv/tb_region_homogeneity_stats.sv
// Self-checking testbench for region_homogeneity_stats: random pixel regions, tolerance writes.
module tb_region_homogeneity_stats;
  import rhs_pkg::*;

  // Slack after the last expected result before a tolerance write or the end of the run.
  // Covers the front pipeline, the two-entry queue and the serial divider with margin.
  localparam int DRAIN_CYCLES = 40;
  // Pixels in the random part, spread over eight tolerance phases.
  localparam int RANDOM_PIXELS = 1300;
  localparam int RANDOM_PHASES = 8;
  // In time units. Even with every pixel closing a region under the longest idles on
  // both sides the run needs well under 100k time units; allow many times that.
  localparam int RUN_LIMIT = 1_000_000;

  typedef struct packed {
    logic [CH_W-1:0] mean_red;
    logic [CH_W-1:0] mean_green;
    logic [CH_W-1:0] mean_blue;
    logic homogeneous;
    logic [MAG_W-1:0] spread;
  } region_stats_t;

  logic clk = 1'b0;
  logic rst;

  rhs_pixel_if pix_if ();
  rhs_result_if res_if ();
  rhs_cfg_if cfg_if ();

  region_homogeneity_stats dut (
    .clk(clk),
    .rst(rst),
    .pix(pix_if),
    .res(res_if),
    .cfg(cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Region accumulators mirrored from the block, plus the tolerance register.
  longint unsigned acc_red;
  longint unsigned acc_green;
  longint unsigned acc_blue;
  int unsigned acc_count;
  logic [MAG_W-1:0] mag_min;
  logic [MAG_W-1:0] mag_max;
  logic [TOL_W-1:0] tolerance_q;

  // Region results the block still owes, oldest first.
  region_stats_t expected_regions[$];

  int unsigned mismatch_count = 0;

  // When set, the corresponding side never idles between requests.
  bit source_full_rate = 1'b0;
  bit sink_full_rate = 1'b0;

  // Floor of the square root, resolved one root bit at a time from the top.
  function automatic logic [MAG_W-1:0] pixel_magnitude(input logic [CH_W-1:0] r,
                                                       input logic [CH_W-1:0] g,
                                                       input logic [CH_W-1:0] b);
    logic [19:0] energy;
    logic [10:0] root;
    logic [10:0] trial;
    energy = 20'(r) * 20'(r) + 20'(g) * 20'(g) + 20'(b) * 20'(b);
    root = '0;
    for (int k = 10; k >= 0; k--) begin
      trial = root | (11'(1) << k);
      if (22'(trial) * 22'(trial) <= 22'(energy))
        root = trial;
    end
    return root[MAG_W-1:0];
  endfunction

  function automatic void clear_region_stats();
    acc_red = 0;
    acc_green = 0;
    acc_blue = 0;
    acc_count = 0;
    mag_min = '1;
    mag_max = '0;
  endfunction

  // Folds one accepted pixel into the region; a marked pixel closes the region
  // and queues the statistics the block must report for it.
  function automatic void accumulate_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                           input logic [CH_W-1:0] b, input logic last);
    region_stats_t stats;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] spread;
    mag = pixel_magnitude(r, g, b);
    if (mag < mag_min)
      mag_min = mag;
    if (mag > mag_max)
      mag_max = mag;
    // past the bound only min/max keep moving
    if (acc_count < MAX_REGION_PIXELS) begin
      acc_red += r;
      acc_green += g;
      acc_blue += b;
      acc_count++;
    end
    if (last) begin
      spread = mag_max - mag_min;
      stats.mean_red = CH_W'(acc_red / acc_count);
      stats.mean_green = CH_W'(acc_green / acc_count);
      stats.mean_blue = CH_W'(acc_blue / acc_count);
      stats.homogeneous = (TOL_W'(spread) < tolerance_q);
      stats.spread = spread;
      expected_regions.push_back(stats);
      clear_region_stats();
    end
  endfunction

  function automatic void check_field(input string field, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // One pixel request: optional idle gap, then hold valid until the block takes it.
  // Always entered at a rising edge; valid gets a single update per time step.
  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b, input logic last);
    int unsigned gap;
    gap = source_full_rate ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.red_in <= r;
    pix_if.green_in <= g;
    pix_if.blue_in <= b;
    pix_if.last_pixel <= last;
    do @(posedge clk); while (!pix_if.ready);
    accumulate_pixel(r, g, b, last);
  endtask

  // Sender holds off until every owed result is back and the pipeline is empty.
  task automatic drain_regions();
    pix_if.valid <= 1'b0;
    while (expected_regions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Tolerance writes happen only with the block idle.
  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    drain_regions();
    cfg_if.valid <= 1'b1;
    cfg_if.tolerance <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    tolerance_q = value;
  endtask

  // One region of random content. Styles: uniform noise, flat with small jitter
  // (spread near typical tolerances), channels at 0 or 255, flat with wider jitter.
  task automatic send_random_region(input int unsigned len);
    int unsigned style;
    int unsigned jitter;
    logic [CH_W-1:0] base_r;
    logic [CH_W-1:0] base_g;
    logic [CH_W-1:0] base_b;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    style = $urandom_range(0, 3);
    jitter = (style == 1) ? 4 : 24;
    base_r = CH_W'($urandom_range(0, 255 - jitter));
    base_g = CH_W'($urandom_range(0, 255 - jitter));
    base_b = CH_W'($urandom_range(0, 255 - jitter));
    for (int k = 0; k < len; k++) begin
      case (style)
        0: begin
          r = CH_W'($urandom);
          g = CH_W'($urandom);
          b = CH_W'($urandom);
        end
        2: begin
          r = $urandom_range(0, 1) ? '1 : '0;
          g = $urandom_range(0, 1) ? '1 : '0;
          b = $urandom_range(0, 1) ? '1 : '0;
        end
        default: begin
          r = base_r + CH_W'($urandom_range(0, jitter));
          g = base_g + CH_W'($urandom_range(0, jitter));
          b = base_b + CH_W'($urandom_range(0, jitter));
        end
      endcase
      send_pixel(r, g, b, k == len - 1);
    end
  endtask

  // Reset tolerance (32): single-pixel regions, full-scale spread, spread just
  // under and at the tolerance, and truncation of the means.
  task automatic test_reset_tolerance_regions();
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd31, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd32, 8'd0, 1'b1);
    send_pixel(8'd1, 8'd1, 8'd1, 1'b0);
    send_pixel(8'd1, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd1, 8'd1, 1'b1);
    send_pixel(8'd254, 8'd255, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd254, 8'd129, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd128, 1'b1);
  endtask

  // Tolerance at both ends of its range and around the largest possible spread.
  task automatic test_tolerance_limits();
    write_tolerance('0);
    send_pixel(8'd7, 8'd7, 8'd7, 1'b1);
    write_tolerance('1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    write_tolerance(TOL_W'(441));
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    write_tolerance(TOL_W'(442));
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
  endtask

  // Random regions under several tolerance settings, with phases where one or
  // both sides run without idling, and occasional full drains mid-phase.
  task automatic test_random_regions();
    int unsigned sent;
    int unsigned len;
    logic [TOL_W-1:0] tol;
    sent = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0)
        tol = '0;
      else if (phase == 1)
        tol = '1;
      else if ($urandom_range(0, 1) != 0)
        tol = TOL_W'($urandom_range(0, 48));
      else
        tol = TOL_W'($urandom_range(0, 1023));
      write_tolerance(tol);
      source_full_rate = (phase == 2 || phase == 5);
      sink_full_rate = (phase == 3 || phase == 5);
      while (sent < (phase + 1) * RANDOM_PIXELS / RANDOM_PHASES) begin
        len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 24);
        send_random_region(len);
        sent += len;
        if ($urandom_range(0, 15) == 0)
          drain_regions();
      end
    end
    source_full_rate = 1'b0;
    sink_full_rate = 1'b0;
  endtask

  // Result side: random stall before each result, then take and compare it.
  initial begin : result_checker
    int unsigned stall;
    region_stats_t want;
    res_if.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = sink_full_rate ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      if (expected_regions.size() == 0) begin
        $error("result request with no region pending");
        mismatch_count++;
      end else begin
        want = expected_regions.pop_front();
        check_field("mean_red", want.mean_red, res_if.mean_red);
        check_field("mean_green", want.mean_green, res_if.mean_green);
        check_field("mean_blue", want.mean_blue, res_if.mean_blue);
        check_field("homogeneous", want.homogeneous, res_if.homogeneous);
        check_field("magnitude_spread", want.spread, res_if.magnitude_spread);
      end
    end
  end

  initial begin
    rst = 1'b1;
    pix_if.valid = 1'b0;
    pix_if.red_in = '0;
    pix_if.green_in = '0;
    pix_if.blue_in = '0;
    pix_if.last_pixel = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.tolerance = '0;
    tolerance_q = TOL_RESET;
    clear_region_stats();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_tolerance_regions();
    test_tolerance_limits();
    test_random_regions();

    // let every owed result arrive, then watch for strays
    drain_regions();
    if (mismatch_count == 0)
      $display("region_homogeneity_stats: match");
    else
      $display("region_homogeneity_stats: mismatch");
    $finish;
  end

  // Hang guard
  initial begin
    #(RUN_LIMIT);
    $display("region_homogeneity_stats: mismatch");
    $finish;
  end

endmodule
